@@ hdl/cvlm_pkg.sv @@
// ----------------------------------------------------------------------------
// cvlm_pkg
// Shared types, register indexes, level codes and defaults for the
// confirmed vital level monitor.
// ----------------------------------------------------------------------------
package cvlm_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned TIME_W     = 32;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam int unsigned TEMP_W   = 10;
  localparam int unsigned BREATH_W = 8;
  localparam int unsigned HRV_W    = 10;
  localparam int unsigned PULSE_W  = 9;
  localparam int unsigned DRY_W    = 24;
  localparam int unsigned THIRST_W = 16;

  localparam int unsigned SECS_PER_MINUTE = 60;
  localparam int unsigned CRITICAL_FACTOR = 2;

  localparam int unsigned TEMP_HOLD_MS_DEF   = 5000;
  localparam int unsigned BREATH_HOLD_MS_DEF = 5000;
  localparam int unsigned HRV_HOLD_MS_DEF    = 5000;
  localparam int unsigned PULSE_HOLD_MS_DEF  = 5000;
  localparam int unsigned THIRST_HOLD_MS_DEF = 5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEVER_LIMIT       = 4'd0,
    REG_HYPOTHERMIA_LIMIT = 4'd1,
    REG_BREATH_RATE_MAX   = 4'd2,
    REG_BREATH_RATE_MIN   = 4'd3,
    REG_HRV_STRESS_LIMIT  = 4'd4,
    REG_PULSE_HIGH_LIMIT  = 4'd5,
    REG_PULSE_LOW_LIMIT   = 4'd6,
    REG_THIRST_MINUTES    = 4'd7
  } reg_idx_t;

  // level codes
  localparam logic [LEVEL_W-1:0] TEMP_LVL_NORMAL  = 2'd0;
  localparam logic [LEVEL_W-1:0] TEMP_LVL_FEVER   = 2'd1;
  localparam logic [LEVEL_W-1:0] TEMP_LVL_HYPO    = 2'd2;
  localparam logic [LEVEL_W-1:0] BREATH_NORMAL    = 2'd0;
  localparam logic [LEVEL_W-1:0] BREATH_LOW       = 2'd1;
  localparam logic [LEVEL_W-1:0] BREATH_ELEVATED  = 2'd2;
  localparam logic [LEVEL_W-1:0] HRV_LVL_UNKNOWN  = 2'd0;
  localparam logic [LEVEL_W-1:0] HRV_LVL_STABLE   = 2'd1;
  localparam logic [LEVEL_W-1:0] HRV_LVL_STRESSED = 2'd2;
  localparam logic [LEVEL_W-1:0] PULSE_UNKNOWN    = 2'd0;
  localparam logic [LEVEL_W-1:0] PULSE_STABLE     = 2'd1;
  localparam logic [LEVEL_W-1:0] PULSE_HIGH       = 2'd2;
  localparam logic [LEVEL_W-1:0] PULSE_LOW        = 2'd3;
  localparam logic [LEVEL_W-1:0] THIRST_NONE      = 2'd0;
  localparam logic [LEVEL_W-1:0] THIRST_DETECTED  = 2'd1;
  localparam logic [LEVEL_W-1:0] THIRST_CRITICAL  = 2'd2;

  typedef struct packed {
    logic [TEMP_W-1:0]   fever_limit;
    logic [TEMP_W-1:0]   hypothermia_limit;
    logic [BREATH_W-1:0] breath_rate_max;
    logic [BREATH_W-1:0] breath_rate_min;
    logic [HRV_W-1:0]    hrv_stress_limit;
    logic [PULSE_W-1:0]  pulse_high_limit;
    logic [PULSE_W-1:0]  pulse_low_limit;
    logic [THIRST_W-1:0] thirst_minutes;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]   now_ms;
    logic [TEMP_W-1:0]   body_temp;
    logic [BREATH_W-1:0] breath_rate;
    logic [HRV_W-1:0]    hrv_ms;
    logic [PULSE_W-1:0]  pulse_bpm;
    logic [DRY_W-1:0]    seconds_since_drink;
  } sample_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] temp;
    logic [LEVEL_W-1:0] breath;
    logic [LEVEL_W-1:0] hrv;
    logic [LEVEL_W-1:0] pulse;
    logic [LEVEL_W-1:0] thirst;
  } levels_t;

endpackage

@@ hdl/cvlm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cvlm_cfg_regs
// Threshold register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module cvlm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [cvlm_pkg::CFG_IDX_W-1:0]   wr_idx,
  input  logic [cvlm_pkg::CFG_DATA_W-1:0]  wr_data,
  output cvlm_pkg::cfg_t                   cfg
);

  cvlm_pkg::cfg_t cfg_r;
  cvlm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cvlm_pkg::reg_idx_t'(wr_idx))
        cvlm_pkg::REG_FEVER_LIMIT:
          cfg_nxt.fever_limit = wr_data[cvlm_pkg::TEMP_W-1:0];
        cvlm_pkg::REG_HYPOTHERMIA_LIMIT:
          cfg_nxt.hypothermia_limit = wr_data[cvlm_pkg::TEMP_W-1:0];
        cvlm_pkg::REG_BREATH_RATE_MAX:
          cfg_nxt.breath_rate_max = wr_data[cvlm_pkg::BREATH_W-1:0];
        cvlm_pkg::REG_BREATH_RATE_MIN:
          cfg_nxt.breath_rate_min = wr_data[cvlm_pkg::BREATH_W-1:0];
        cvlm_pkg::REG_HRV_STRESS_LIMIT:
          cfg_nxt.hrv_stress_limit = wr_data[cvlm_pkg::HRV_W-1:0];
        cvlm_pkg::REG_PULSE_HIGH_LIMIT:
          cfg_nxt.pulse_high_limit = wr_data[cvlm_pkg::PULSE_W-1:0];
        cvlm_pkg::REG_PULSE_LOW_LIMIT:
          cfg_nxt.pulse_low_limit = wr_data[cvlm_pkg::PULSE_W-1:0];
        cvlm_pkg::REG_THIRST_MINUTES:
          cfg_nxt.thirst_minutes = wr_data[cvlm_pkg::THIRST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fever_limit       <= 10'd395;
      cfg_r.hypothermia_limit <= 10'd375;
      cfg_r.breath_rate_max   <= 8'd30;
      cfg_r.breath_rate_min   <= 8'd10;
      cfg_r.hrv_stress_limit  <= 10'd50;
      cfg_r.pulse_high_limit  <= 9'd140;
      cfg_r.pulse_low_limit   <= 9'd60;
      cfg_r.thirst_minutes    <= 16'd240;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/cvlm_classify.sv @@
// ----------------------------------------------------------------------------
// cvlm_classify
// Sorts one sample into raw levels for all five channels.
// ----------------------------------------------------------------------------
module cvlm_classify (
  input  cvlm_pkg::sample_t  sample,
  input  cvlm_pkg::cfg_t     cfg,
  output cvlm_pkg::levels_t  raw
);

  localparam int unsigned LIM_W  = cvlm_pkg::THIRST_W + 6;
  localparam int unsigned CRIT_W = LIM_W + 1;

  logic [LIM_W-1:0]  dry_limit;
  logic [CRIT_W-1:0] dry_crit;
  logic [CRIT_W:0]   dry_ext;

  assign dry_limit = LIM_W'(cfg.thirst_minutes) * LIM_W'(cvlm_pkg::SECS_PER_MINUTE);
  assign dry_crit  = CRIT_W'(dry_limit) * CRIT_W'(cvlm_pkg::CRITICAL_FACTOR);
  assign dry_ext   = (CRIT_W+1)'(sample.seconds_since_drink);

  always_comb begin
    if (sample.body_temp > cfg.fever_limit)
      raw.temp = cvlm_pkg::TEMP_LVL_FEVER;
    else if (sample.body_temp < cfg.hypothermia_limit)
      raw.temp = cvlm_pkg::TEMP_LVL_HYPO;
    else
      raw.temp = cvlm_pkg::TEMP_LVL_NORMAL;

    if (sample.breath_rate > cfg.breath_rate_max)
      raw.breath = cvlm_pkg::BREATH_ELEVATED;
    else if (sample.breath_rate < cfg.breath_rate_min)
      raw.breath = cvlm_pkg::BREATH_LOW;
    else
      raw.breath = cvlm_pkg::BREATH_NORMAL;

    if (sample.hrv_ms == '0)
      raw.hrv = cvlm_pkg::HRV_LVL_UNKNOWN;
    else if (sample.hrv_ms < cfg.hrv_stress_limit)
      raw.hrv = cvlm_pkg::HRV_LVL_STRESSED;
    else
      raw.hrv = cvlm_pkg::HRV_LVL_STABLE;

    if (sample.pulse_bpm == '0)
      raw.pulse = cvlm_pkg::PULSE_UNKNOWN;
    else if (sample.pulse_bpm > cfg.pulse_high_limit)
      raw.pulse = cvlm_pkg::PULSE_HIGH;
    else if (sample.pulse_bpm < cfg.pulse_low_limit)
      raw.pulse = cvlm_pkg::PULSE_LOW;
    else
      raw.pulse = cvlm_pkg::PULSE_STABLE;

    if (dry_ext > (CRIT_W+1)'(dry_crit))
      raw.thirst = cvlm_pkg::THIRST_CRITICAL;
    else if (dry_ext > (CRIT_W+1)'(dry_limit))
      raw.thirst = cvlm_pkg::THIRST_DETECTED;
    else
      raw.thirst = cvlm_pkg::THIRST_NONE;
  end

endmodule

@@ hdl/cvlm_qualify.sv @@
// ----------------------------------------------------------------------------
// cvlm_qualify
// Debounce for one channel: candidate level, its start time and the
// confirmed level.
// ----------------------------------------------------------------------------
module cvlm_qualify #(
  parameter int unsigned                   HOLD_MS     = cvlm_pkg::TEMP_HOLD_MS_DEF,
  parameter logic [cvlm_pkg::LEVEL_W-1:0]  RESET_LEVEL = '0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [cvlm_pkg::LEVEL_W-1:0]     raw,
  input  logic [cvlm_pkg::TIME_W-1:0]      now,
  output logic [cvlm_pkg::LEVEL_W-1:0]     level_nxt
);

  localparam logic [cvlm_pkg::TIME_W-1:0] HOLD = cvlm_pkg::TIME_W'(HOLD_MS);

  logic [cvlm_pkg::LEVEL_W-1:0] conf_r, conf_nxt;
  logic [cvlm_pkg::LEVEL_W-1:0] cand_r, cand_nxt;
  logic [cvlm_pkg::TIME_W-1:0]  since_r, since_nxt;
  logic [cvlm_pkg::TIME_W-1:0]  elapsed;

  assign elapsed = now - since_r;

  always_comb begin
    conf_nxt  = conf_r;
    cand_nxt  = cand_r;
    since_nxt = since_r;
    if (raw != conf_r) begin
      if (raw != cand_r) begin
        cand_nxt  = raw;
        since_nxt = now;
      end else if (elapsed >= HOLD) begin
        conf_nxt = raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_r  <= RESET_LEVEL;
      cand_r  <= RESET_LEVEL;
      since_r <= '0;
    end else if (en) begin
      conf_r  <= conf_nxt;
      cand_r  <= cand_nxt;
      since_r <= since_nxt;
    end
  end

  assign level_nxt = conf_nxt;

endmodule

@@ hdl/confirmed_vital_level_monitor.sv @@
// ----------------------------------------------------------------------------
// confirmed_vital_level_monitor
// Vital-sign level classifier with per-channel confirm times.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sample per transfer. in_tdata carries now_ms, body_temp,
//           breath_rate, hrv_ms, pulse_bpm and seconds_since_drink.
//   out_* : one result per sample with the five confirmed levels.
//   cfg_* : threshold writes, index 0..7; other indexes are ignored.
//           cfg_ready is always high; write only while the block is idle.
//   Timing: a sample is first held in the input register; its result is
//   written to the output register, which drives out_tvalid, once the
//   output is free.
//   Throughput: one sample per cycle while out_tready is high; the debounce
//   state of each channel is read and updated in the same cycle the sample
//   leaves the input register.
//   Reset: thresholds return to defaults, all channels return to their
//   reset levels with zero timestamps, both registers empty.
//   Stall: while out_tready is low the result holds, one more sample is
//   taken into the input register, then in_tready drops.
// ----------------------------------------------------------------------------
module confirmed_vital_level_monitor #(
  parameter int unsigned TEMP_HOLD_MS   = cvlm_pkg::TEMP_HOLD_MS_DEF,
  parameter int unsigned BREATH_HOLD_MS = cvlm_pkg::BREATH_HOLD_MS_DEF,
  parameter int unsigned HRV_HOLD_MS    = cvlm_pkg::HRV_HOLD_MS_DEF,
  parameter int unsigned PULSE_HOLD_MS  = cvlm_pkg::PULSE_HOLD_MS_DEF,
  parameter int unsigned THIRST_HOLD_MS = cvlm_pkg::THIRST_HOLD_MS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // now_ms[31:0], body_temp[41:32], breath_rate[49:42], hrv_ms[59:50],
  // pulse_bpm[68:60], seconds_since_drink[92:69], zero[95:93]
  input  logic [cvlm_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // temp_level[1:0], breath_level[3:2], hrv_level[5:4], pulse_level[7:6],
  // thirst_level[9:8], zero[15:10]
  output logic [cvlm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cvlm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cvlm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  cvlm_pkg::cfg_t    cfg;
  cvlm_pkg::sample_t sample_r, sample_nxt;
  cvlm_pkg::levels_t raw;
  cvlm_pkg::levels_t lvl_nxt;
  logic              in_valid_r;
  logic              out_valid_r;
  logic [cvlm_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic              advance;

  assign cfg_ready = 1'b1;

  cvlm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    sample_nxt.now_ms              = in_tdata[31:0];
    sample_nxt.body_temp           = in_tdata[41:32];
    sample_nxt.breath_rate         = in_tdata[49:42];
    sample_nxt.hrv_ms              = in_tdata[59:50];
    sample_nxt.pulse_bpm           = in_tdata[68:60];
    sample_nxt.seconds_since_drink = in_tdata[92:69];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sample_r <= sample_nxt;
    end
  end

  cvlm_classify u_classify (
    .sample (sample_r),
    .cfg    (cfg),
    .raw    (raw)
  );

  cvlm_qualify #(.HOLD_MS(TEMP_HOLD_MS), .RESET_LEVEL(cvlm_pkg::TEMP_LVL_NORMAL)) u_q_temp (
    .clk (clk), .rst_n (rst_n), .en (advance), .raw (raw.temp),
    .now (sample_r.now_ms), .level_nxt (lvl_nxt.temp)
  );

  cvlm_qualify #(.HOLD_MS(BREATH_HOLD_MS), .RESET_LEVEL(cvlm_pkg::BREATH_NORMAL)) u_q_breath (
    .clk (clk), .rst_n (rst_n), .en (advance), .raw (raw.breath),
    .now (sample_r.now_ms), .level_nxt (lvl_nxt.breath)
  );

  cvlm_qualify #(.HOLD_MS(HRV_HOLD_MS), .RESET_LEVEL(cvlm_pkg::HRV_LVL_STABLE)) u_q_hrv (
    .clk (clk), .rst_n (rst_n), .en (advance), .raw (raw.hrv),
    .now (sample_r.now_ms), .level_nxt (lvl_nxt.hrv)
  );

  cvlm_qualify #(.HOLD_MS(PULSE_HOLD_MS), .RESET_LEVEL(cvlm_pkg::PULSE_UNKNOWN)) u_q_pulse (
    .clk (clk), .rst_n (rst_n), .en (advance), .raw (raw.pulse),
    .now (sample_r.now_ms), .level_nxt (lvl_nxt.pulse)
  );

  cvlm_qualify #(.HOLD_MS(THIRST_HOLD_MS), .RESET_LEVEL(cvlm_pkg::THIRST_NONE)) u_q_thirst (
    .clk (clk), .rst_n (rst_n), .en (advance), .raw (raw.thirst),
    .now (sample_r.now_ms), .level_nxt (lvl_nxt.thirst)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'd0, lvl_nxt.thirst, lvl_nxt.pulse, lvl_nxt.hrv,
                     lvl_nxt.breath, lvl_nxt.temp};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("processed sample did not produce a result");

  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while both registers are full");

  a_temp_level_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3 && out_tdata[3:2] != 2'd3))
    else $error("temperature or respiration level out of range");

  a_thirst_level_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:4] != 2'd3 && out_tdata[9:8] != 2'd3))
    else $error("hrv or thirst level out of range");
`endif

endmodule
